[src/quaternion_to_euler_top_assert.svh]
// assertion macros shared by the quaternion to euler checker
`ifndef QUATERNION_TO_EULER_TOP_ASSERT_SVH
`define QUATERNION_TO_EULER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define QTE_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("qte assertion failed");

// next-cycle implication, disabled while reset is low
`define QTE_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("qte assertion failed");

`endif

[src/qte_pkg.sv]
// shared types, widths and the arctangent table for the quaternion to euler pipeline
package qte_pkg;

    localparam int QUAT_WIDTH      = 16;
    localparam int QUAT_FRAC_BITS  = 14;
    localparam int ANGLE_WIDTH_DEF = 16;

    localparam int PROD_W     = 2 * QUAT_WIDTH;
    localparam int OP_W       = PROD_W + 3;
    localparam int PITCH_FRAC = 30;
    localparam int P_W        = PITCH_FRAC + 1;
    localparam int PITCH_SHIFT = PITCH_FRAC - 2 * QUAT_FRAC_BITS;
    localparam int SQ_W       = 2 * P_W;
    localparam int SQRT_TOP   = 2 * PITCH_FRAC;
    localparam int SQRT_STEPS = PITCH_FRAC + 1;

    localparam int NORM_TOP   = 41;
    localparam int NORM_W     = NORM_TOP + 1;
    localparam int NORM_STEPS = 6;
    localparam int CX_W       = NORM_W + 2;
    localparam int ZW         = 34;
    localparam int CORDIC_STEPS = 32;

    localparam logic signed [OP_W-1:0] QUAT_ONE   = OP_W'(1) << (2 * QUAT_FRAC_BITS);
    localparam logic [SQ_W-1:0]        SQ_ONE     = SQ_W'(1) << SQRT_TOP;
    localparam logic signed [ZW-1:0]   Z_HALF     = ZW'(1) << 31;
    localparam logic signed [ZW-1:0]   Z_QUARTER  = ZW'(1) << 30;

    typedef struct packed {
        logic signed [OP_W-1:0] sr;
        logic signed [OP_W-1:0] cr;
        logic signed [OP_W-1:0] sy;
        logic signed [OP_W-1:0] cy;
        logic signed [P_W-1:0]  p;
        logic                   sat;
        logic                   neg;
    } ops_t;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
    } sqrt_vec_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic [NORM_W-1:0]        m;
        logic signed [ZW-1:0]     z;
        logic                     zero;
    } norm_vec_t;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [ZW-1:0]   z;
        logic                   zero;
    } cordic_vec_t;

    // atan(2^-i) in units of 2^-31 half turns
    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ZW-1:0] val;
        unique case (idx)
            5'd0:  val = 34'h020000000;
            5'd1:  val = 34'h012E4051E;
            5'd2:  val = 34'h009FB385B;
            5'd3:  val = 34'h0051111D4;
            5'd4:  val = 34'h0028B0D43;
            5'd5:  val = 34'h00145D7E1;
            5'd6:  val = 34'h000A2F61E;
            5'd7:  val = 34'h000517C55;
            5'd8:  val = 34'h00028BE53;
            5'd9:  val = 34'h000145F2F;
            5'd10: val = 34'h0000A2F98;
            5'd11: val = 34'h0000517CC;
            5'd12: val = 34'h000028BE6;
            5'd13: val = 34'h0000145F3;
            5'd14: val = 34'h00000A2FA;
            5'd15: val = 34'h00000517D;
            5'd16: val = 34'h0000028BE;
            5'd17: val = 34'h00000145F;
            5'd18: val = 34'h000000A30;
            5'd19: val = 34'h000000518;
            5'd20: val = 34'h00000028C;
            5'd21: val = 34'h000000146;
            5'd22: val = 34'h0000000A3;
            5'd23: val = 34'h000000051;
            5'd24: val = 34'h000000029;
            5'd25: val = 34'h000000014;
            5'd26: val = 34'h00000000A;
            5'd27: val = 34'h000000005;
            5'd28: val = 34'h000000003;
            5'd29: val = 34'h000000001;
            5'd30: val = 34'h000000001;
            5'd31: val = 34'h000000000;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

[src/qte_sqrt_cell.sv]
// one digit cell of the pipelined integer square root
module qte_sqrt_cell #(
    parameter int BIT_POS = 0
) (
    input  logic                  aclk,
    input  logic                  en,
    input  qte_pkg::sqrt_vec_t    d_in,
    output qte_pkg::sqrt_vec_t    d_out
);

    localparam logic [qte_pkg::SQ_W-1:0] BIT = qte_pkg::SQ_W'(1) << BIT_POS;

    qte_pkg::sqrt_vec_t q_reg;
    qte_pkg::sqrt_vec_t q_next;
    logic [qte_pkg::SQ_W-1:0] trial;

    always_comb begin
        trial = d_in.r + BIT;
        if (d_in.v >= trial) begin
            q_next.v = d_in.v - trial;
            q_next.r = (d_in.r >> 1) + BIT;
        end else begin
            q_next.v = d_in.v;
            q_next.r = d_in.r >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign d_out = q_reg;

endmodule

[src/qte_norm_cell.sv]
// one conditional left shift cell of the operand normalizer
module qte_norm_cell #(
    parameter int STEP = 1
) (
    input  logic                  aclk,
    input  logic                  en,
    input  qte_pkg::norm_vec_t    d_in,
    output qte_pkg::norm_vec_t    d_out
);

    localparam logic [qte_pkg::NORM_W-1:0] LIMIT =
        qte_pkg::NORM_W'(1) << (qte_pkg::NORM_TOP - STEP);

    qte_pkg::norm_vec_t q_reg;
    qte_pkg::norm_vec_t q_next;

    always_comb begin
        q_next = d_in;
        if (d_in.m < LIMIT) begin
            q_next.x = d_in.x <<< STEP;
            q_next.y = d_in.y <<< STEP;
            q_next.m = d_in.m << STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign d_out = q_reg;

endmodule

[src/qte_cordic_cell.sv]
// one vectoring rotation cell of the cordic arctangent
module qte_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                   aclk,
    input  logic                   en,
    input  qte_pkg::cordic_vec_t   d_in,
    output qte_pkg::cordic_vec_t   d_out
);

    localparam logic signed [qte_pkg::ZW-1:0] ATAN = qte_pkg::atan_entry(5'(STEP));

    qte_pkg::cordic_vec_t q_reg;
    qte_pkg::cordic_vec_t q_next;
    logic signed [qte_pkg::CX_W-1:0] dx;
    logic signed [qte_pkg::CX_W-1:0] dy;

    always_comb begin
        dx = d_in.y >>> STEP;
        dy = d_in.x >>> STEP;
        q_next.zero = d_in.zero;
        if (!d_in.y[qte_pkg::CX_W-1]) begin
            q_next.x = d_in.x + dx;
            q_next.y = d_in.y - dy;
            q_next.z = d_in.z + ATAN;
        end else begin
            q_next.x = d_in.x - dx;
            q_next.y = d_in.y + dy;
            q_next.z = d_in.z - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign d_out = q_reg;

endmodule

[src/qte_prep.sv]
// quadrant fold and magnitude pick ahead of the normalizer
module qte_prep (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [qte_pkg::OP_W-1:0]    a,
    input  logic signed [qte_pkg::OP_W-1:0]    b,
    output qte_pkg::norm_vec_t                 d_out
);

    qte_pkg::norm_vec_t q_reg;
    qte_pkg::norm_vec_t q_next;
    logic signed [qte_pkg::OP_W-1:0] a_neg;
    logic signed [qte_pkg::OP_W-1:0] b_neg;
    logic signed [qte_pkg::OP_W-1:0] x;
    logic signed [qte_pkg::OP_W-1:0] y;
    logic [qte_pkg::OP_W-1:0] a_mag;
    logic [qte_pkg::OP_W-1:0] b_mag;
    logic flip;

    always_comb begin
        a_neg = -a;
        b_neg = -b;
        flip  = b[qte_pkg::OP_W-1];
        a_mag = a[qte_pkg::OP_W-1] ? a_neg : a;
        b_mag = flip ? b_neg : b;
        x     = flip ? b_neg : b;
        y     = flip ? a_neg : a;
        q_next.x    = qte_pkg::NORM_W'(x);
        q_next.y    = qte_pkg::NORM_W'(y);
        q_next.m    = qte_pkg::NORM_W'((a_mag > b_mag) ? a_mag : b_mag);
        q_next.zero = (a == '0) && (b == '0);
        if (flip) begin
            q_next.z = a[qte_pkg::OP_W-1] ? -qte_pkg::Z_HALF : qte_pkg::Z_HALF;
        end else begin
            q_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign d_out = q_reg;

endmodule

[src/quaternion_to_euler_top.sv]
// quaternion to roll, pitch and yaw top level
// throughput: one request per cycle while the skid register is empty, set by the
//   fully pipelined square root, normalizer and cordic cell rows that all advance together
// an output register plus a skid register hold finished results; s_tready drops
//   only while the skid register is full
// reset clears the valid bits of every stage, the output and the skid register
module quaternion_to_euler_top #(
    parameter int ANGLE_WIDTH = qte_pkg::ANGLE_WIDTH_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // quat_w, quat_x, quat_y, quat_z
    input  logic [4*qte_pkg::QUAT_WIDTH-1:0]         s_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // roll_angle, pitch_angle, yaw_angle, zero fill
    output logic [((3*ANGLE_WIDTH+7)/8)*8-1:0]       m_tdata
);

    localparam int AW     = ANGLE_WIDTH;
    localparam int OUT_W  = ((3 * AW + 7) / 8) * 8;
    localparam int QW     = qte_pkg::QUAT_WIDTH;
    localparam int OPS_DLY = qte_pkg::SQRT_STEPS + 2;
    localparam int PT_DLY  = 1 + qte_pkg::NORM_STEPS + qte_pkg::CORDIC_STEPS;
    localparam int LAT    = 5 + qte_pkg::SQRT_STEPS + PT_DLY + 1;
    localparam int SH     = 32 - AW;
    localparam int ZR_W   = qte_pkg::ZW + 1;
    localparam logic signed [ZR_W-1:0] ROUND_HALF = ZR_W'((64'd1 << SH) >> 1);
    localparam logic signed [ZR_W-1:0] CODE_HI = ZR_W'((64'sd1 <<< (AW - 1)) - 1);
    localparam logic signed [ZR_W-1:0] CODE_LO = -ZR_W'(64'sd1 <<< (AW - 1));

    logic adv;
    logic [LAT-1:0] vld_reg;

    logic signed [QW-1:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [qte_pkg::PROD_W-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg;
    logic signed [qte_pkg::PROD_W-1:0] zx_reg, wz_reg, xy_reg, zz_reg;

    qte_pkg::ops_t ops_reg;
    qte_pkg::ops_t ops_next;
    qte_pkg::ops_t ops_dly_reg [OPS_DLY];
    logic signed [qte_pkg::OP_W-1:0] sp_full;

    logic signed [qte_pkg::SQ_W-1:0] psq_full;
    logic [qte_pkg::SQ_W-1:0] psq_reg;
    logic [qte_pkg::SQ_W-1:0] rad_reg;

    qte_pkg::sqrt_vec_t sq_vec [qte_pkg::SQRT_STEPS+1];
    logic [qte_pkg::P_W-1:0] cos_p;

    logic [1:0] pt_reg [PT_DLY];

    logic signed [qte_pkg::OP_W-1:0] ch_a [3];
    logic signed [qte_pkg::OP_W-1:0] ch_b [3];
    qte_pkg::norm_vec_t   nv [3][qte_pkg::NORM_STEPS+1];
    qte_pkg::cordic_vec_t cv [3][qte_pkg::CORDIC_STEPS+1];

    logic [3*AW-1:0] code_reg;
    logic [3*AW-1:0] code_next;

    logic            m_tvalid_reg;
    logic [3*AW-1:0] m_data_reg;
    logic            skid_vld_reg;
    logic [3*AW-1:0] skid_data_reg;
    logic            deliver;
    logic            out_free;

    assign adv      = !skid_vld_reg;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // input, product and sum stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            qw_reg <= s_tdata[QW-1:0];
            qx_reg <= s_tdata[2*QW-1:QW];
            qy_reg <= s_tdata[3*QW-1:2*QW];
            qz_reg <= s_tdata[4*QW-1:3*QW];
            wx_reg <= qw_reg * qx_reg;
            yz_reg <= qy_reg * qz_reg;
            xx_reg <= qx_reg * qx_reg;
            yy_reg <= qy_reg * qy_reg;
            wy_reg <= qw_reg * qy_reg;
            zx_reg <= qz_reg * qx_reg;
            wz_reg <= qw_reg * qz_reg;
            xy_reg <= qx_reg * qy_reg;
            zz_reg <= qz_reg * qz_reg;
            ops_reg <= ops_next;
        end
    end

    always_comb begin
        ops_next.sr = (qte_pkg::OP_W'(wx_reg) + qte_pkg::OP_W'(yz_reg)) <<< 1;
        ops_next.cr = qte_pkg::QUAT_ONE
                    - ((qte_pkg::OP_W'(xx_reg) + qte_pkg::OP_W'(yy_reg)) <<< 1);
        ops_next.sy = (qte_pkg::OP_W'(wz_reg) + qte_pkg::OP_W'(xy_reg)) <<< 1;
        ops_next.cy = qte_pkg::QUAT_ONE
                    - ((qte_pkg::OP_W'(yy_reg) + qte_pkg::OP_W'(zz_reg)) <<< 1);
        sp_full     = (qte_pkg::OP_W'(wy_reg) - qte_pkg::OP_W'(zx_reg)) <<< 1;
        ops_next.p  = qte_pkg::P_W'(sp_full <<< qte_pkg::PITCH_SHIFT);
        ops_next.sat = (sp_full >= qte_pkg::QUAT_ONE) || (sp_full <= -qte_pkg::QUAT_ONE);
        ops_next.neg = sp_full[qte_pkg::OP_W-1];
    end

    // pitch cosine: square, subtract from one, square root cells
    assign psq_full = $signed(ops_reg.p) * $signed(ops_reg.p);

    always_ff @(posedge aclk) begin
        if (adv) begin
            psq_reg <= qte_pkg::SQ_W'(psq_full);
            rad_reg <= qte_pkg::SQ_ONE - psq_reg;
            ops_dly_reg[0] <= ops_reg;
            for (int k = 1; k < OPS_DLY; k++) begin
                ops_dly_reg[k] <= ops_dly_reg[k-1];
            end
            pt_reg[0] <= {ops_dly_reg[OPS_DLY-1].sat, ops_dly_reg[OPS_DLY-1].neg};
            for (int k = 1; k < PT_DLY; k++) begin
                pt_reg[k] <= pt_reg[k-1];
            end
        end
    end

    assign sq_vec[0].v = rad_reg;
    assign sq_vec[0].r = '0;

    for (genvar k = 0; k < qte_pkg::SQRT_STEPS; k++) begin : g_sqrt
        qte_sqrt_cell #(
            .BIT_POS(qte_pkg::SQRT_TOP - 2 * k)
        ) u_cell (
            .aclk  (aclk),
            .en    (adv),
            .d_in  (sq_vec[k]),
            .d_out (sq_vec[k+1])
        );
    end

    assign cos_p = sq_vec[qte_pkg::SQRT_STEPS].r[qte_pkg::P_W-1:0];

    // roll, pitch, yaw channels
    assign ch_a[0] = ops_dly_reg[OPS_DLY-1].sr;
    assign ch_b[0] = ops_dly_reg[OPS_DLY-1].cr;
    assign ch_a[1] = qte_pkg::OP_W'($signed(ops_dly_reg[OPS_DLY-1].p));
    assign ch_b[1] = $signed(qte_pkg::OP_W'(cos_p));
    assign ch_a[2] = ops_dly_reg[OPS_DLY-1].sy;
    assign ch_b[2] = ops_dly_reg[OPS_DLY-1].cy;

    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        qte_prep u_prep (
            .aclk  (aclk),
            .en    (adv),
            .a     (ch_a[ch]),
            .b     (ch_b[ch]),
            .d_out (nv[ch][0])
        );

        for (genvar j = 0; j < qte_pkg::NORM_STEPS; j++) begin : g_norm
            qte_norm_cell #(
                .STEP(32 >> j)
            ) u_cell (
                .aclk  (aclk),
                .en    (adv),
                .d_in  (nv[ch][j]),
                .d_out (nv[ch][j+1])
            );
        end

        assign cv[ch][0].x    = qte_pkg::CX_W'(nv[ch][qte_pkg::NORM_STEPS].x);
        assign cv[ch][0].y    = qte_pkg::CX_W'(nv[ch][qte_pkg::NORM_STEPS].y);
        assign cv[ch][0].z    = nv[ch][qte_pkg::NORM_STEPS].z;
        assign cv[ch][0].zero = nv[ch][qte_pkg::NORM_STEPS].zero;

        for (genvar i = 0; i < qte_pkg::CORDIC_STEPS; i++) begin : g_cordic
            qte_cordic_cell #(
                .STEP(i)
            ) u_cell (
                .aclk  (aclk),
                .en    (adv),
                .d_in  (cv[ch][i]),
                .d_out (cv[ch][i+1])
            );
        end

        logic signed [qte_pkg::ZW-1:0] zf;
        logic signed [ZR_W-1:0] zr;
        logic signed [ZR_W-1:0] zq;
        logic [AW-1:0] code_c;

        always_comb begin
            if (cv[ch][qte_pkg::CORDIC_STEPS].zero) begin
                zf = '0;
            end else begin
                zf = cv[ch][qte_pkg::CORDIC_STEPS].z;
            end
            if (ch == 1 && pt_reg[PT_DLY-1][1]) begin
                zf = pt_reg[PT_DLY-1][0] ? -qte_pkg::Z_QUARTER : qte_pkg::Z_QUARTER;
            end
            zr = ZR_W'(zf) + ROUND_HALF;
            zq = zr >>> SH;
            if (zq > CODE_HI) begin
                zq = CODE_HI;
            end else if (zq < CODE_LO) begin
                zq = CODE_LO;
            end
            code_c = zq[AW-1:0];
        end
    end

    assign code_next = {g_chan[2].code_c, g_chan[1].code_c, g_chan[0].code_c};

    always_ff @(posedge aclk) begin
        if (adv) begin
            code_reg <= code_next;
        end
    end

    // output register with skid
    assign deliver  = adv && vld_reg[LAT-1];
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_vld_reg) begin
                m_tvalid_reg <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                m_tvalid_reg <= deliver;
            end
        end else if (deliver) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_data_reg <= skid_vld_reg ? skid_data_reg : code_reg;
        end else if (deliver) begin
            skid_data_reg <= code_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'(m_data_reg);

endmodule

[src/qte_checker.sv]
// port-level assertions for the quaternion to euler top level
`include "quaternion_to_euler_top_assert.svh"

module qte_checker #(
    parameter int ANGLE_WIDTH = qte_pkg::ANGLE_WIDTH_DEF
) (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_tready,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((3*ANGLE_WIDTH+7)/8)*8-1:0]    m_tdata
);

    localparam logic signed [ANGLE_WIDTH-1:0] PITCH_MAX =
        ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
    localparam logic signed [ANGLE_WIDTH-1:0] PITCH_MIN = -PITCH_MAX;

    logic signed [ANGLE_WIDTH-1:0] pitch_f;

    assign pitch_f = m_tdata[2*ANGLE_WIDTH-1:ANGLE_WIDTH];

    `QTE_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))
    `QTE_ASSERT_IMP(a_pitch_range, aclk, aresetn, m_tvalid,
        pitch_f <= PITCH_MAX && pitch_f >= PITCH_MIN)
    `QTE_ASSERT_IMP(a_stall_has_result, aclk, aresetn, !s_tready, m_tvalid)
    `QTE_ASSERT_IMP(a_stall_cause, aclk, aresetn, $fell(s_tready),
        $past(m_tvalid && !m_tready))

endmodule

bind quaternion_to_euler_top qte_checker #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
) u_qte_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
